FILE: rtl/core/bfha_pkg.sv
// Package for the best-fit heap allocator: sizes, status and register codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package bfha_pkg;

	// sizing of heap, free-extent table and request fields
	localparam int HEAP_UNITS  = 65536;
	localparam int MAX_EXTENTS = 64;
	localparam int UNIT_BYTES  = 16;
	localparam int ADDR_W      = $clog2(HEAP_UNITS);
	localparam int UNITS_W     = ADDR_W + 1;
	localparam int IDX_W       = $clog2(MAX_EXTENTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
	localparam int SIZE_W      = 20;
	localparam int STAT_W      = 2;
	localparam int CFG_IDX_W   = 1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_MEM   = 2'd1;
	localparam logic [STAT_W-1:0] ST_TBL_FULL = 2'd2;

	// request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_GROW   = 1'b1;

	// reset values of the configuration registers
	localparam logic [UNITS_W-1:0] HEAP_LIMIT_RST = UNITS_W'(65536);
	localparam logic [UNITS_W-1:0] MIN_GROW_RST   = UNITS_W'(1024);

	// datapath operations issued by the controller
	typedef enum logic [5:0] {
		OP_NOP, OP_CLR, OP_LOAD, OP_HDR_RD, OP_FR_TAKE,
		OP_IN_INIT, OP_RD_J, OP_IN_EV, OP_RD_T, OP_RD_P, OP_CAP_P,
		OP_SET_FULL, OP_IN_UPLOW, OP_IN_UP, OP_IN_LOW, OP_SH_INIT,
		OP_SH_RD, OP_SH_WR, OP_IN_PUT, OP_DR_RD, OP_DR_WR, OP_DR_END,
		OP_SC_INIT, OP_SC_RD, OP_SC_EV, OP_SC_EXACT, OP_SC_BEST,
		OP_SET_OOM, OP_DIV_START, OP_GR_SETG, OP_RD_LAST, OP_GR_COMMIT,
		OP_RSP_LOAD
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_mode;
		logic in_addr_zero;
		logic clr_last;
		logic j_lt_cnt;
		logic p_eq_cnt;
		logic j_eq_p;
		logic jp1_lt_cnt;
		logic k_lt_cnt;
		logic exact;
		logic fit;
		logic hdr_zero;
		logic up;
		logic low;
		logic tbl_full;
		logic div_done;
		logic over;
		logic merge;
		logic rsp_free;
	} stat_t;

endpackage

FILE: rtl/core/bfha_if.sv
// Channel interfaces of the best-fit heap allocator: request, response and
// configuration write. Depends on bfha_pkg.
interface bfha_req_if;
	import bfha_pkg::*;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [SIZE_W-1:0] size_bytes;
	logic [ADDR_W-1:0] address;
	modport source (output valid, mode, size_bytes, address, input ready);
	modport sink (input valid, mode, size_bytes, address, output ready);
endinterface

interface bfha_rsp_if;
	import bfha_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ADDR_W-1:0] block_address;
	modport source (output valid, status, block_address, input ready);
	modport sink (input valid, status, block_address, output ready);
endinterface

interface bfha_cfg_if;
	import bfha_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [UNITS_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bfha_rem.sv
// Iterative restoring divider that yields the remainder, one bit per cycle.
// Depends on bfha_pkg.
module bfha_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bfha_pkg::UNITS_W-1:0]  dividend,
	input  logic [bfha_pkg::UNITS_W-1:0]  divisor,
	output logic                          done,
	output logic [bfha_pkg::UNITS_W-1:0]  rem
);
	import bfha_pkg::*;

	localparam int CW = $clog2(UNITS_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [UNITS_W-1:0] dvd_q;
	logic [UNITS_W-1:0] dsr_q;
	logic [UNITS_W-1:0] rem_q;
	logic [UNITS_W:0]   trial;

	// shift in the next dividend bit
	assign trial = {rem_q, dvd_q[UNITS_W-1]};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(UNITS_W);
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= UNITS_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= UNITS_W'(trial);
			end
			dvd_q <= {dvd_q[UNITS_W-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/bfha_dp.sv
// Datapath of the best-fit heap allocator: extent table, header store,
// bookkeeping registers and response register. Depends on bfha_pkg,
// bfha_if and bfha_rem.
module bfha_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  bfha_pkg::cmd_t  cmd,
	output bfha_pkg::stat_t stat,
	bfha_req_if.sink        req,
	bfha_rsp_if.source      rsp,
	bfha_cfg_if.sink        cfg
);
	import bfha_pkg::*;

	// extent table and header store
	logic [ADDR_W-1:0]  start_mem [MAX_EXTENTS];
	logic [UNITS_W-1:0] units_mem [MAX_EXTENTS];
	logic [UNITS_W-1:0] hdr_mem   [HEAP_UNITS];

	logic [UNITS_W-1:0] limit_q, mgu_q, brk_q, need_q, h_q, sz_q, g_q;
	logic [CNT_W-1:0]   count_q, j_q, k_q;
	logic [IDX_W-1:0]   rover_q, idx_q, t_q, best_q;
	logic               have_q;
	logic [UNITS_W-1:0] mindiff_q, best_units_q, un_t_q, un_p_q;
	logic [ADDR_W-1:0]  best_start_q, st_t_q, st_p_q;
	logic [STAT_W-1:0]  status_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  clr_q;
	logic               rsp_valid_q;
	logic [STAT_W-1:0]  rsp_status_q;
	logic [ADDR_W-1:0]  rsp_addr_q;

	logic [ADDR_W-1:0]  rd_start_q;
	logic [UNITS_W-1:0] rd_units_q;
	logic               rd_zero_q;
	logic [UNITS_W-1:0] hdr_rd_q;

	logic [ADDR_W-1:0]  rd_start;
	logic [UNITS_W-1:0] rd_units;
	logic [SIZE_W:0]    sz_round;
	logic [UNITS_W-1:0] need_in, lim, diff, best_left;
	logic [CNT_W-1:0]   p, cnt_m1, idx_p1, rover_p1;
	logic [CNT_W:0]     jp1;
	logic [ADDR_W+1:0]  blk;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_start_en, wr_units_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]  wr_start_d;
	logic [UNITS_W-1:0] wr_units_d;
	logic               hdr_we;
	logic [ADDR_W-1:0]  hdr_waddr;
	logic [UNITS_W-1:0] hdr_wdata;

	logic               div_done;
	logic [UNITS_W-1:0] div_rem;

	// growth remainder unit
	bfha_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.dividend (mgu_q),
		.divisor  (need_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// entry 0 is the sentinel and always reads as zero
	assign rd_start = rd_zero_q ? '0 : rd_start_q;
	assign rd_units = rd_zero_q ? '0 : rd_units_q;

	// derived values
	assign sz_round  = {1'b0, req.size_bytes} + (SIZE_W+1)'(UNIT_BYTES - 1);
	assign need_in   = UNITS_W'(sz_round >> UNIT_SHIFT) + UNITS_W'(1);
	assign lim       = (limit_q > UNITS_W'(HEAP_UNITS)) ? UNITS_W'(HEAP_UNITS) : limit_q;
	assign diff      = rd_units - need_q;
	assign best_left = best_units_q - need_q;
	assign blk       = {2'b0, best_start_q} + {1'b0, best_left};
	assign p         = {1'b0, t_q} + CNT_W'(1);
	assign cnt_m1    = count_q - CNT_W'(1);
	assign idx_p1    = {1'b0, idx_q} + CNT_W'(1);
	assign rover_p1  = {1'b0, rover_q} + CNT_W'(1);
	assign jp1       = {1'b0, j_q} + (CNT_W+1)'(1);

	// table read address per operation
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = j_q[IDX_W-1:0];
		unique case (cmd.op)
			OP_RD_J:    rd_addr = j_q[IDX_W-1:0];
			OP_RD_T:    rd_addr = t_q;
			OP_RD_P:    rd_addr = p[IDX_W-1:0];
			OP_SH_RD:   rd_addr = j_q[IDX_W-1:0];
			OP_DR_RD:   rd_addr = jp1[IDX_W-1:0];
			OP_SC_RD:   rd_addr = idx_q;
			OP_RD_LAST: rd_addr = cnt_m1[IDX_W-1:0];
			default:    rd_en   = 1'b0;
		endcase
	end

	// table write per operation
	always_comb begin
		wr_start_en = 1'b0;
		wr_units_en = 1'b0;
		wr_addr     = t_q;
		wr_start_d  = h_q[ADDR_W-1:0];
		wr_units_d  = sz_q;
		unique case (cmd.op)
			OP_IN_UPLOW: begin
				wr_units_en = 1'b1;
				wr_units_d  = un_t_q + sz_q + un_p_q;
			end
			OP_IN_UP: begin
				wr_start_en = 1'b1;
				wr_units_en = 1'b1;
				wr_addr     = p[IDX_W-1:0];
				wr_units_d  = sz_q + un_p_q;
			end
			OP_IN_LOW: begin
				wr_units_en = 1'b1;
				wr_units_d  = un_t_q + sz_q;
			end
			OP_SH_WR: begin
				wr_start_en = 1'b1;
				wr_units_en = 1'b1;
				wr_addr     = jp1[IDX_W-1:0];
				wr_start_d  = rd_start;
				wr_units_d  = rd_units;
			end
			OP_IN_PUT: begin
				wr_start_en = 1'b1;
				wr_units_en = 1'b1;
				wr_addr     = p[IDX_W-1:0];
			end
			OP_DR_WR: begin
				wr_start_en = 1'b1;
				wr_units_en = 1'b1;
				wr_addr     = j_q[IDX_W-1:0];
				wr_start_d  = rd_start;
				wr_units_d  = rd_units;
			end
			OP_SC_BEST: begin
				wr_units_en = 1'b1;
				wr_addr     = best_q;
				wr_units_d  = best_left;
			end
			default: begin
			end
		endcase
	end

	// header store write per operation
	always_comb begin
		hdr_we    = 1'b0;
		hdr_waddr = clr_q;
		hdr_wdata = '0;
		unique case (cmd.op)
			OP_CLR:     hdr_we = 1'b1;
			OP_FR_TAKE: begin
				hdr_we    = 1'b1;
				hdr_waddr = h_q[ADDR_W-1:0];
			end
			OP_SC_EXACT: begin
				hdr_we    = 1'b1;
				hdr_waddr = rd_start;
				hdr_wdata = need_q;
			end
			OP_SC_BEST: begin
				hdr_we    = blk < (ADDR_W+2)'(HEAP_UNITS);
				hdr_waddr = blk[ADDR_W-1:0];
				hdr_wdata = need_q;
			end
			default: begin
			end
		endcase
	end

	// extent table memory
	always_ff @(posedge clk) begin
		if (wr_start_en) start_mem[wr_addr] <= wr_start_d;
		if (wr_units_en) units_mem[wr_addr] <= wr_units_d;
		if (rd_en) begin
			rd_start_q <= start_mem[rd_addr];
			rd_units_q <= units_mem[rd_addr];
			rd_zero_q  <= (rd_addr == '0);
		end
	end

	// header memory
	always_ff @(posedge clk) begin
		if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
		if (cmd.op == OP_HDR_RD) hdr_rd_q <= hdr_mem[h_q[ADDR_W-1:0]];
	end

	// bookkeeping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= HEAP_LIMIT_RST;
			mgu_q        <= MIN_GROW_RST;
			brk_q        <= UNITS_W'(1);
			count_q      <= CNT_W'(1);
			rover_q      <= '0;
			clr_q        <= '0;
			need_q       <= '0;
			h_q          <= '0;
			sz_q         <= '0;
			g_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			idx_q        <= '0;
			t_q          <= '0;
			best_q       <= '0;
			have_q       <= 1'b0;
			mindiff_q    <= '0;
			best_units_q <= '0;
			best_start_q <= '0;
			un_t_q       <= '0;
			un_p_q       <= '0;
			st_t_q       <= '0;
			st_p_q       <= '0;
			status_q     <= ST_OK;
			addr_q       <= '0;
		end else begin
			// configuration writes
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_HEAP_LIMIT: limit_q <= cfg.data;
					CFG_MIN_GROW:   mgu_q   <= cfg.data;
					default: begin
					end
				endcase
			end
			unique case (cmd.op)
				OP_CLR: clr_q <= clr_q + ADDR_W'(1);
				OP_LOAD: begin
					need_q   <= need_in;
					h_q      <= UNITS_W'(req.address) - UNITS_W'(1);
					status_q <= ST_OK;
					addr_q   <= '0;
				end
				OP_FR_TAKE: sz_q <= hdr_rd_q;
				OP_IN_INIT: begin
					t_q <= '0;
					j_q <= CNT_W'(1);
				end
				OP_IN_EV: begin
					if ({1'b0, rd_start} < h_q) t_q <= j_q[IDX_W-1:0];
					j_q <= j_q + CNT_W'(1);
				end
				OP_RD_P: begin
					st_t_q <= rd_start;
					un_t_q <= rd_units;
				end
				OP_CAP_P: begin
					st_p_q <= rd_start;
					un_p_q <= rd_units;
				end
				OP_SET_FULL: status_q <= ST_TBL_FULL;
				OP_IN_UPLOW: begin
					rover_q <= t_q;
					j_q     <= p;
				end
				OP_IN_UP:  rover_q <= t_q;
				OP_IN_LOW: rover_q <= t_q;
				OP_SH_INIT: begin
					rover_q <= t_q;
					j_q     <= cnt_m1;
				end
				OP_SH_WR: j_q <= j_q - CNT_W'(1);
				OP_IN_PUT: begin
					rover_q <= t_q;
					count_q <= count_q + CNT_W'(1);
				end
				OP_DR_WR:  j_q     <= j_q + CNT_W'(1);
				OP_DR_END: count_q <= cnt_m1;
				OP_SC_INIT: begin
					idx_q  <= (rover_p1 >= count_q) ? '0 : rover_p1[IDX_W-1:0];
					k_q    <= '0;
					have_q <= 1'b0;
				end
				OP_SC_EV: begin
					if (rd_units > need_q && (!have_q || diff < mindiff_q)) begin
						have_q       <= 1'b1;
						mindiff_q    <= diff;
						best_q       <= idx_q;
						best_start_q <= rd_start;
						best_units_q <= rd_units;
					end
					idx_q <= (idx_p1 == count_q) ? '0 : idx_p1[IDX_W-1:0];
					k_q   <= k_q + CNT_W'(1);
				end
				OP_SC_EXACT: begin
					j_q     <= {1'b0, idx_q};
					rover_q <= idx_q - IDX_W'(1);
					addr_q  <= rd_start + ADDR_W'(1);
				end
				OP_SC_BEST: begin
					rover_q <= best_q - IDX_W'(1);
					addr_q  <= blk[ADDR_W-1:0] + ADDR_W'(1);
				end
				OP_SET_OOM: begin
					status_q <= ST_NO_MEM;
					addr_q   <= '0;
				end
				OP_GR_SETG: g_q <= (need_q < mgu_q) ? mgu_q - div_rem : need_q;
				OP_GR_COMMIT: begin
					h_q   <= brk_q;
					sz_q  <= g_q;
					brk_q <= brk_q + g_q;
				end
				default: begin
				end
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_addr_q   <= '0;
		end else if (cmd.op == OP_RSP_LOAD) begin
			rsp_valid_q  <= 1'b1;
			rsp_status_q <= status_q;
			rsp_addr_q   <= addr_q;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.block_address = rsp_addr_q;
	assign req.ready         = cmd.in_ready;
	assign cfg.ready         = 1'b1;

	// status back to the controller
	always_comb begin
		stat.in_valid     = req.valid;
		stat.in_mode      = req.mode;
		stat.in_addr_zero = (req.address == '0);
		stat.clr_last     = &clr_q;
		stat.j_lt_cnt     = j_q < count_q;
		stat.p_eq_cnt     = p == count_q;
		stat.j_eq_p       = j_q == p;
		stat.jp1_lt_cnt   = jp1 < {1'b0, count_q};
		stat.k_lt_cnt     = k_q < count_q;
		stat.exact        = (rd_units == need_q) && (idx_q != '0);
		stat.fit          = have_q && (best_q != '0);
		stat.hdr_zero     = (hdr_rd_q == '0);
		stat.up           = (p < count_q) &&
		                    ({1'b0, h_q} + {1'b0, sz_q} == {2'b0, st_p_q});
		stat.low          = (t_q != '0) &&
		                    ({2'b0, st_t_q} + {1'b0, un_t_q} == {1'b0, h_q});
		stat.tbl_full     = count_q >= CNT_W'(MAX_EXTENTS);
		stat.div_done     = div_done;
		stat.over         = ({1'b0, brk_q} + {1'b0, g_q}) > {1'b0, lim};
		stat.merge        = (cnt_m1 != '0) &&
		                    ({2'b0, rd_start} + {1'b0, rd_units} == {1'b0, brk_q});
		stat.rsp_free     = !rsp_valid_q || rsp.ready;
	end

	// table bookkeeping stays consistent
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CNT_W'(MAX_EXTENTS))
		else $error("extent count out of range");

	a_rover_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rover_q} < count_q)
		else $error("rover beyond table");

	a_break_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q != '0 && brk_q <= UNITS_W'(HEAP_UNITS))
		else $error("heap break out of range");

endmodule

FILE: rtl/core/bfha_ctrl.sv
// Controller of the best-fit heap allocator: sequences scan, insert, shift,
// drop and growth steps on the datapath. Depends on bfha_pkg.
module bfha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  bfha_pkg::stat_t stat,
	output bfha_pkg::cmd_t  cmd
);
	import bfha_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_FR_RD, S_FR_CHK, S_IN_INIT, S_IN_RD, S_IN_EV,
		S_IN_RDP, S_IN_CAPP, S_IN_ACT, S_SH_RD, S_SH_WR, S_SH_PUT,
		S_DR_RD, S_DR_WR, S_SC_INIT, S_SC_RD, S_SC_EV, S_SC_END,
		S_GR_WAIT, S_GR_RDL, S_GR_CHK, S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   ret_grow_q, grown_q, drop_ins_q;
	state_t ins_done;

	// where an insert returns to
	assign ins_done = ret_grow_q ? S_SC_INIT : S_FIN;

	// next state and command
	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NOP;
		cmd.in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (stat.in_valid) begin
					cmd.op = OP_LOAD;
					priority if (stat.in_mode == MODE_ALLOC) state_d = S_SC_INIT;
					else if (stat.in_addr_zero) state_d = S_FIN;
					else state_d = S_FR_RD;
				end
			end
			S_FR_RD: begin
				cmd.op  = OP_HDR_RD;
				state_d = S_FR_CHK;
			end
			S_FR_CHK: begin
				if (stat.hdr_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_FR_TAKE;
					state_d = S_IN_INIT;
				end
			end
			// insert: find the last entry below the new extent
			S_IN_INIT: begin
				cmd.op  = OP_IN_INIT;
				state_d = S_IN_RD;
			end
			S_IN_RD: begin
				if (stat.j_lt_cnt) begin
					cmd.op  = OP_RD_J;
					state_d = S_IN_EV;
				end else begin
					cmd.op  = OP_RD_T;
					state_d = S_IN_RDP;
				end
			end
			S_IN_EV: begin
				cmd.op  = OP_IN_EV;
				state_d = S_IN_RD;
			end
			S_IN_RDP: begin
				cmd.op  = OP_RD_P;
				state_d = S_IN_CAPP;
			end
			S_IN_CAPP: begin
				cmd.op  = OP_CAP_P;
				state_d = S_IN_ACT;
			end
			// insert: merge with neighbors or open a slot
			S_IN_ACT: begin
				priority if (stat.up && stat.low) begin
					cmd.op  = OP_IN_UPLOW;
					state_d = S_DR_RD;
				end else if (stat.up) begin
					cmd.op  = OP_IN_UP;
					state_d = ins_done;
				end else if (stat.low) begin
					cmd.op  = OP_IN_LOW;
					state_d = ins_done;
				end else if (stat.tbl_full) begin
					if (!ret_grow_q) cmd.op = OP_SET_FULL;
					state_d = ins_done;
				end else if (stat.p_eq_cnt) begin
					cmd.op  = OP_IN_PUT;
					state_d = ins_done;
				end else begin
					cmd.op  = OP_SH_INIT;
					state_d = S_SH_RD;
				end
			end
			S_SH_RD: begin
				cmd.op  = OP_SH_RD;
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				cmd.op  = OP_SH_WR;
				state_d = stat.j_eq_p ? S_SH_PUT : S_SH_RD;
			end
			S_SH_PUT: begin
				cmd.op  = OP_IN_PUT;
				state_d = ins_done;
			end
			// drop an entry by shifting the tail down
			S_DR_RD: begin
				if (stat.jp1_lt_cnt) begin
					cmd.op  = OP_DR_RD;
					state_d = S_DR_WR;
				end else begin
					cmd.op  = OP_DR_END;
					state_d = drop_ins_q ? ins_done : S_FIN;
				end
			end
			S_DR_WR: begin
				cmd.op  = OP_DR_WR;
				state_d = S_DR_RD;
			end
			// best-fit scan round the ring
			S_SC_INIT: begin
				cmd.op  = OP_SC_INIT;
				state_d = S_SC_RD;
			end
			S_SC_RD: begin
				if (stat.k_lt_cnt) begin
					cmd.op  = OP_SC_RD;
					state_d = S_SC_EV;
				end else begin
					state_d = S_SC_END;
				end
			end
			S_SC_EV: begin
				if (stat.exact) begin
					cmd.op  = OP_SC_EXACT;
					state_d = S_DR_RD;
				end else begin
					cmd.op  = OP_SC_EV;
					state_d = S_SC_RD;
				end
			end
			S_SC_END: begin
				priority if (stat.fit) begin
					cmd.op  = OP_SC_BEST;
					state_d = S_FIN;
				end else if (!grown_q) begin
					cmd.op  = OP_DIV_START;
					state_d = S_GR_WAIT;
				end else begin
					cmd.op  = OP_SET_OOM;
					state_d = S_FIN;
				end
			end
			// heap growth
			S_GR_WAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_GR_SETG;
					state_d = S_GR_RDL;
				end
			end
			S_GR_RDL: begin
				cmd.op  = OP_RD_LAST;
				state_d = S_GR_CHK;
			end
			S_GR_CHK: begin
				priority if (stat.over) begin
					cmd.op  = OP_SET_OOM;
					state_d = S_FIN;
				end else if (!stat.merge && stat.tbl_full) begin
					cmd.op  = OP_SET_FULL;
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_GR_COMMIT;
					state_d = S_IN_INIT;
				end
			end
			S_FIN: begin
				if (stat.rsp_free) begin
					cmd.op  = OP_RSP_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and flow flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ret_grow_q <= 1'b0;
			grown_q    <= 1'b0;
			drop_ins_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (cmd.op)
				OP_LOAD: begin
					ret_grow_q <= 1'b0;
					grown_q    <= 1'b0;
				end
				OP_GR_COMMIT: begin
					ret_grow_q <= 1'b1;
					grown_q    <= 1'b1;
				end
				OP_SC_EXACT: drop_ins_q <= 1'b0;
				OP_IN_UPLOW: drop_ins_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/best_fit_heap_allocator_top.sv
// Top level of the best-fit heap allocator: controller plus datapath.
// Depends on bfha_pkg, bfha_if, bfha_ctrl and bfha_dp.
//
// Usage:
// - req carries one item: mode (allocate or free), size_bytes, address.
// - rsp returns one item per request: status and block_address.
// - cfg writes heap_limit (index 0) or min_grow_units (index 1); always ready.
// - After reset the header store is cleared one entry a cycle, and req.ready
//   stays low until it is done; cfg writes are taken meanwhile.
// - One request is worked at a time. A scan reads each table entry in turn, an
//   insert searches the table for the position and moves entries up to open a
//   slot, a drop moves the tail entries down, and growth runs the remainder
//   unit and then an insert and a second scan. A free of address 0 or of an
//   unknown block goes to the result without a scan.
// - The result goes to an output register; req.ready returns as soon as the
//   result is loaded, so the next request starts while the result waits.
// - If rsp stalls while a second result is ready, the block holds it until
//   the output register is taken.
module best_fit_heap_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	bfha_req_if.sink   req,
	bfha_rsp_if.source rsp,
	bfha_cfg_if.sink   cfg
);
	import bfha_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	bfha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// tables, registers and channels
	bfha_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule
